@@ hw/rtl/aopr_pkg.sv @@
package aopr_pkg;

  localparam int unsigned BLOB_W = 6;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned FRAME_W = 32;
  localparam int unsigned OP_W = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MARK_W = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [OP_W-1:0] OP_DIST = 2'd0;
  localparam logic [OP_W-1:0] OP_CHANGE = 2'd1;
  localparam logic [OP_W-1:0] OP_SPEED = 2'd2;

  localparam logic [MARK_W-1:0] MARK_NONE = 2'd0;
  localparam logic [MARK_W-1:0] MARK_UNSPLIT = 2'd1;
  localparam logic [MARK_W-1:0] MARK_SPLIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_LOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL_LIM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_LIM = 3'd4;

  typedef enum logic [1:0] {
    CMD_DIST,
    CMD_CHANGE,
    CMD_SPEED
  } cmd_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [FRAME_W-1:0]       frame;
    logic [BLOB_W-1:0]        first_blob;
    logic [BLOB_W-1:0]        second_blob;
    logic signed [VAL_W-1:0]  amount;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] split_low;
    logic signed [VAL_W-1:0] split_high;
    logic signed [VAL_W-1:0] change_thr;
    logic signed [VAL_W-1:0] still_lim;
    logic signed [VAL_W-1:0] leave_lim;
  } cfg_t;

  typedef struct packed {
    logic                     valid;
    logic [FRAME_W-1:0]       frame;
    logic [BLOB_W-1:0]        still_blob;
    logic [BLOB_W-1:0]        leaving_blob;
    logic signed [VAL_W-1:0]  change_seen;
    logic signed [VAL_W-1:0]  still_speed;
    logic signed [VAL_W-1:0]  leaving_speed;
  } alarm_t;

endpackage

@@ hw/rtl/aopr_ram.sv @@
module aopr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/aopr_front.sv @@
module aopr_front #(
  parameter int unsigned NUM_BLOBS = 64
) (
  input  logic                        start,
  output logic                        busy,
  input  logic [aopr_pkg::OP_W-1:0]   op_i,
  input  logic [aopr_pkg::FRAME_W-1:0] frame_i,
  input  logic [aopr_pkg::BLOB_W-1:0] first_blob_i,
  input  logic [aopr_pkg::BLOB_W-1:0] second_blob_i,
  input  logic signed [aopr_pkg::VAL_W-1:0] amount_i,
  input  logic                        queue_full_i,
  input  logic                        clearing_i,
  output logic                        push_o,
  output aopr_pkg::item_t             item_o
);
  import aopr_pkg::*;

  localparam int unsigned NB = (NUM_BLOBS < (2 ** BLOB_W)) ? NUM_BLOBS : (2 ** BLOB_W);

  logic first_ok;
  logic second_ok;
  logic keep;
  cmd_e cmd;

  assign first_ok = {1'b0, first_blob_i} < (BLOB_W + 1)'(NB);
  assign second_ok = {1'b0, second_blob_i} < (BLOB_W + 1)'(NB);

  always_comb begin
    keep = 1'b0;
    cmd = CMD_DIST;
    case (op_i)
      OP_DIST: begin
        keep = first_ok && second_ok;
        cmd = CMD_DIST;
      end
      OP_CHANGE: begin
        keep = first_ok && second_ok;
        cmd = CMD_CHANGE;
      end
      OP_SPEED: begin
        keep = first_ok;
        cmd = CMD_SPEED;
      end
      default: begin
        keep = 1'b0;
        cmd = CMD_DIST;
      end
    endcase
  end

  assign busy = clearing_i || queue_full_i;
  assign push_o = start && !busy && keep;

  assign item_o.cmd = cmd;
  assign item_o.frame = frame_i;
  assign item_o.first_blob = first_blob_i;
  assign item_o.second_blob = second_blob_i;
  assign item_o.amount = amount_i;

endmodule

@@ hw/rtl/aopr_queue.sv @@
module aopr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  aopr_pkg::item_t item_i,
  input  logic            pop_i,
  output aopr_pkg::item_t head_o,
  output logic            empty_o,
  output logic            full_o
);
  import aopr_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign empty_o = (count_q == '0);
  assign full_o = (count_q == CNT_W'(QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign head_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ hw/rtl/aopr_back.sv @@
module aopr_back #(
  parameter int unsigned NUM_BLOBS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  aopr_pkg::cfg_t  cfg_i,
  input  aopr_pkg::item_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            clearing_o,
  output aopr_pkg::alarm_t alarm_o
);
  import aopr_pkg::*;

  localparam int unsigned NB = (NUM_BLOBS < (2 ** BLOB_W)) ? NUM_BLOBS : (2 ** BLOB_W);
  localparam int unsigned SPD_AW = $clog2(NB);
  localparam int unsigned PAIR_DEPTH = NB * NB;
  localparam int unsigned PAIR_AW = $clog2(PAIR_DEPTH);
  localparam logic [PAIR_AW-1:0] NB_K = PAIR_AW'(NB);
  localparam logic [PAIR_AW-1:0] CLR_LAST = PAIR_AW'(PAIR_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_FETCH = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [PAIR_AW-1:0]  clr_cnt_q;
  item_t               cur_q;
  logic [PAIR_AW-1:0]  cur_key_q;
  logic [NB-1:0]       known_q;
  alarm_t              alarm_q, alarm_d;

  logic [SPD_AW-1:0]   head_a;
  logic [SPD_AW-1:0]   head_b;
  logic [PAIR_AW-1:0]  head_key;
  logic [SPD_AW-1:0]   cur_a;
  logic [SPD_AW-1:0]   cur_b;

  logic                mark_we;
  logic [PAIR_AW-1:0]  mark_waddr;
  logic [MARK_W-1:0]   mark_wdata;
  logic [MARK_W-1:0]   mark_rd;
  logic                spd_we;
  logic [VAL_W-1:0]    spd_a_rd;
  logic [VAL_W-1:0]    spd_b_rd;

  logic signed [VAL_W-1:0] amount;
  logic signed [VAL_W-1:0] sa;
  logic signed [VAL_W-1:0] sb;
  logic                    a_still_b_leaves;
  logic                    b_still_a_leaves;
  logic                    change_ok;
  logic                    in_split;

  assign head_a = head_i.first_blob[SPD_AW-1:0];
  assign head_b = head_i.second_blob[SPD_AW-1:0];
  assign head_key = PAIR_AW'(head_a) * NB_K + PAIR_AW'(head_b);
  assign cur_a = cur_q.first_blob[SPD_AW-1:0];
  assign cur_b = cur_q.second_blob[SPD_AW-1:0];

  assign pop_o = (state_q == ST_FETCH) && !empty_i;
  assign clearing_o = (state_q == ST_CLEAR);

  aopr_ram #(
    .WIDTH(MARK_W),
    .DEPTH(PAIR_DEPTH)
  ) u_mark_ram (
    .clk_i  (clk_i),
    .we_i   (mark_we),
    .waddr_i(mark_waddr),
    .wdata_i(mark_wdata),
    .raddr_i(head_key),
    .rdata_o(mark_rd)
  );

  aopr_ram #(
    .WIDTH(VAL_W),
    .DEPTH(NB)
  ) u_speed_a_ram (
    .clk_i  (clk_i),
    .we_i   (spd_we),
    .waddr_i(cur_a),
    .wdata_i(cur_q.amount),
    .raddr_i(head_a),
    .rdata_o(spd_a_rd)
  );

  aopr_ram #(
    .WIDTH(VAL_W),
    .DEPTH(NB)
  ) u_speed_b_ram (
    .clk_i  (clk_i),
    .we_i   (spd_we),
    .waddr_i(cur_a),
    .wdata_i(cur_q.amount),
    .raddr_i(head_b),
    .rdata_o(spd_b_rd)
  );

  assign amount = cur_q.amount;
  assign sa = spd_a_rd;
  assign sb = spd_b_rd;
  assign a_still_b_leaves = (sa < cfg_i.still_lim) && (sb > cfg_i.leave_lim);
  assign b_still_a_leaves = (sa > cfg_i.leave_lim) && (sb < cfg_i.still_lim);
  assign in_split = (amount > cfg_i.split_low) && (amount < cfg_i.split_high);
  assign change_ok = (amount >= cfg_i.change_thr) && (mark_rd == MARK_SPLIT) &&
                     known_q[cur_a] && known_q[cur_b];

  always_comb begin
    mark_we = 1'b0;
    mark_waddr = cur_key_q;
    mark_wdata = in_split ? MARK_SPLIT : MARK_UNSPLIT;
    spd_we = 1'b0;
    alarm_d = alarm_q;
    alarm_d.valid = 1'b0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        mark_we = 1'b1;
        mark_waddr = clr_cnt_q;
        mark_wdata = MARK_NONE;
        if (clr_cnt_q == CLR_LAST) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (!empty_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_FETCH;
        case (cur_q.cmd)
          CMD_DIST: begin
            mark_we = (mark_rd == MARK_NONE);
          end
          CMD_SPEED: begin
            spd_we = 1'b1;
          end
          CMD_CHANGE: begin
            if (change_ok && (a_still_b_leaves || b_still_a_leaves)) begin
              alarm_d.valid = 1'b1;
              alarm_d.frame = cur_q.frame;
              alarm_d.change_seen = amount;
              if (a_still_b_leaves) begin
                alarm_d.still_blob = cur_q.first_blob;
                alarm_d.leaving_blob = cur_q.second_blob;
                alarm_d.still_speed = sa;
                alarm_d.leaving_speed = sb;
              end else begin
                alarm_d.still_blob = cur_q.second_blob;
                alarm_d.leaving_blob = cur_q.first_blob;
                alarm_d.still_speed = sb;
                alarm_d.leaving_speed = sa;
              end
            end
          end
          default: begin
            mark_we = 1'b0;
          end
        endcase
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_cnt_q <= '0;
      known_q <= '0;
      alarm_q <= '0;
    end else begin
      state_q <= state_d;
      alarm_q <= alarm_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (spd_we) begin
        known_q[cur_a] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
      cur_key_q <= head_key;
    end
  end

  assign alarm_o = alarm_q;

endmodule

@@ hw/rtl/abandoned_object_pair_rule.sv @@
// Channel   Direction  Handshake                      Payload
// event     in         start & !busy                  op, frame, first/second blob, amount
// alarm     out        alarm_valid_o, one cycle       frame, still/leaving blob, change, speeds
// config    in         cfg_valid_i & cfg_ready_o      cfg_index_i, cfg_data_i
//
// In the back end each kept item passes through a fetch state, which starts the registered
// read of the pair-mark and speed memories, and an exec state, which compares and writes
// back. A two-item queue sits in front, and items with an unused op code or an out-of-range
// blob that their op uses are dropped on entry. After reset, busy stays high while all the
// MAX_BLOBS*MAX_BLOBS pair-mark entries are cleared (capped at 64 blobs). An alarm shows in
// the cycle after the compare and cannot be held off by the receiver.
module abandoned_object_pair_rule #(
  parameter int unsigned MAX_BLOBS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [aopr_pkg::OP_W-1:0]          op_i,
  input  logic [aopr_pkg::FRAME_W-1:0]       frame_i,
  input  logic [aopr_pkg::BLOB_W-1:0]        first_blob_i,
  input  logic [aopr_pkg::BLOB_W-1:0]        second_blob_i,
  input  logic signed [aopr_pkg::VAL_W-1:0]  amount_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [aopr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [aopr_pkg::VAL_W-1:0]         cfg_data_i,
  output logic                               alarm_valid_o,
  output logic [aopr_pkg::FRAME_W-1:0]       alarm_frame_o,
  output logic [aopr_pkg::BLOB_W-1:0]        still_blob_o,
  output logic [aopr_pkg::BLOB_W-1:0]        leaving_blob_o,
  output logic signed [aopr_pkg::VAL_W-1:0]  change_seen_o,
  output logic signed [aopr_pkg::VAL_W-1:0]  still_speed_o,
  output logic signed [aopr_pkg::VAL_W-1:0]  leaving_speed_o
);
  import aopr_pkg::*;

  cfg_t   cfg_q;
  item_t  push_item;
  item_t  head_item;
  logic   push;
  logic   pop;
  logic   empty;
  logic   full;
  logic   clearing;
  alarm_t alarm;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SPLIT_LOW: cfg_q.split_low <= cfg_data_i;
        CFG_SPLIT_HIGH: cfg_q.split_high <= cfg_data_i;
        CFG_CHANGE_THR: cfg_q.change_thr <= cfg_data_i;
        CFG_STILL_LIM: cfg_q.still_lim <= cfg_data_i;
        CFG_LEAVE_LIM: cfg_q.leave_lim <= cfg_data_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  aopr_front #(
    .NUM_BLOBS(MAX_BLOBS)
  ) u_front (
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .frame_i      (frame_i),
    .first_blob_i (first_blob_i),
    .second_blob_i(second_blob_i),
    .amount_i     (amount_i),
    .queue_full_i (full),
    .clearing_i   (clearing),
    .push_o       (push),
    .item_o       (push_item)
  );

  aopr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .head_o (head_item),
    .empty_o(empty),
    .full_o (full)
  );

  aopr_back #(
    .NUM_BLOBS(MAX_BLOBS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .head_i    (head_item),
    .empty_i   (empty),
    .pop_o     (pop),
    .clearing_o(clearing),
    .alarm_o   (alarm)
  );

  assign alarm_valid_o = alarm.valid;
  assign alarm_frame_o = alarm.frame;
  assign still_blob_o = alarm.still_blob;
  assign leaving_blob_o = alarm.leaving_blob;
  assign change_seen_o = alarm.change_seen;
  assign still_speed_o = alarm.still_speed;
  assign leaving_speed_o = alarm.leaving_speed;

endmodule
